@@ sv/ttbf_pkg.sv @@
// ----------------------------------------------------------------------------
// Ternary text to binary float package
// Shared widths, character codes, microcode types and the control store.
// ----------------------------------------------------------------------------
package ttbf_pkg;

  localparam int INT_DIGITS_DEF  = 20;
  localparam int FRAC_DIGITS_DEF = 10;
  localparam int MANT_BITS_DEF   = 10;

  localparam int CHAR_W   = 8;
  localparam int INT_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int EXP_W    = 5;
  localparam int ICNT_W   = 5;
  localparam int FCNT_W   = 4;
  localparam int WEIGHT_W = 15;

  localparam logic [FRAC_W:0]   FRAC_SCALE = 17'd59049;
  localparam logic [EXP_W-1:0]  EXP_TOP    = 5'd31;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_TWO     = 8'h32;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE = 2'd0;
  localparam step_t STEP_NORM = 2'd1;
  localparam step_t STEP_MANT = 2'd2;
  localparam step_t STEP_EMIT = 2'd3;

  typedef enum logic [1:0] {
    OP_TAKE_CHAR,
    OP_NORMALIZE,
    OP_MANTISSA,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NEWLINE,
    COND_NORM_DONE,
    COND_MANT_DONE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Each step repeats until its condition holds, then jumps to the target.
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    unique case (step)
      STEP_IDLE: w = '{op: OP_TAKE_CHAR, cond: COND_NEWLINE,   target: STEP_NORM};
      STEP_NORM: w = '{op: OP_NORMALIZE, cond: COND_NORM_DONE, target: STEP_MANT};
      STEP_MANT: w = '{op: OP_MANTISSA,  cond: COND_MANT_DONE, target: STEP_EMIT};
      STEP_EMIT: w = '{op: OP_EMIT,      cond: COND_OUT_FREE,  target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Weight of a fraction digit by its position: 3^(9-k), zero past the tenth.
  function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [FCNT_W-1:0] k);
    logic [WEIGHT_W-1:0] w;
    case (k)
      4'd0:    w = 15'd19683;
      4'd1:    w = 15'd6561;
      4'd2:    w = 15'd2187;
      4'd3:    w = 15'd729;
      4'd4:    w = 15'd243;
      4'd5:    w = 15'd81;
      4'd6:    w = 15'd27;
      4'd7:    w = 15'd9;
      4'd8:    w = 15'd3;
      4'd9:    w = 15'd1;
      default: w = 15'd0;
    endcase
    return w;
  endfunction

endpackage

@@ sv/ternary_text_to_binary_float_core.sv @@
// ----------------------------------------------------------------------------
// Ternary text to binary float core
// Parses signed base-3 fixed-point text and emits exact parts plus float fields.
// ----------------------------------------------------------------------------
// Each character other than a newline is taken, and the block is ready for
// the next character in the following cycle. A newline starts a short
// microprogram: one shift per cycle finds the leading one of the integer
// part, then one mantissa bit is made per cycle, and the emit step loads the
// result register once the previous result has been taken. The input is
// held off from the newline transfer until that load.
module ternary_text_to_binary_float_core #(
  parameter int INT_DIGITS  = ttbf_pkg::INT_DIGITS_DEF,
  parameter int FRAC_DIGITS = ttbf_pkg::FRAC_DIGITS_DEF,
  parameter int MANT_BITS   = ttbf_pkg::MANT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ttbf_pkg::CHAR_W-1:0]   char_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          negative,
  output logic [ttbf_pkg::INT_W-1:0]    integer_part,
  output logic [ttbf_pkg::FRAC_W-1:0]   fraction_numerator,
  output logic [ttbf_pkg::EXP_W-1:0]    binary_exponent,
  output logic [MANT_BITS-1:0]          mantissa_bits,
  output logic                          malformed
);
  import ttbf_pkg::*;

  localparam int MC_W = $clog2(MANT_BITS + 1);

  step_t               step;
  step_t               step_next;
  ctrl_word_t          ctrl;

  logic                sign_seen_negative;
  logic                sign_taken;
  logic [INT_W-1:0]    int_accumulator;
  logic [ICNT_W-1:0]   int_digit_count;
  logic [FRAC_W-1:0]   frac_accumulator;
  logic [FCNT_W-1:0]   frac_digit_count;
  logic                after_dot;
  logic                error_seen;

  logic [INT_W-1:0]    work;
  logic [EXP_W-1:0]    exp_count;
  logic [EXP_W-1:0]    int_bits_left;
  logic [FRAC_W-1:0]   remainder;
  logic [MANT_BITS-1:0] mant;
  logic [MC_W-1:0]     mant_count;

  logic                accept;
  logic                is_newline;
  logic                is_sign;
  logic                is_dot;
  logic                is_digit;
  logic [1:0]          digit;
  logic [WEIGHT_W-1:0] weight;
  logic [FRAC_W-1:0]   frac_addend;
  logic [INT_W-1:0]    int_acc_next;
  logic                norm_done;
  logic                mant_last;
  logic                out_free;
  logic                cond_hit;
  logic [FRAC_W:0]     rem_doubled;
  logic                frac_bit;
  logic [FRAC_W-1:0]   remainder_next;
  logic                use_int_bit;
  logic                mant_bit;

  always_comb begin
    ctrl        = ucode_rom(step);
    in_ready    = (ctrl.op == OP_TAKE_CHAR);
    accept      = in_valid & in_ready;

    is_newline  = (char_code == CH_NEWLINE);
    is_sign     = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    is_dot      = (char_code == CH_DOT);
    is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_TWO);
    digit       = 2'(char_code - CH_ZERO);

    int_acc_next = (int_accumulator << 1) + int_accumulator + INT_W'(digit);
    weight       = frac_weight(frac_digit_count);
    if (digit[1]) begin
      frac_addend = {weight, 1'b0};
    end else if (digit[0]) begin
      frac_addend = FRAC_W'(weight);
    end else begin
      frac_addend = '0;
    end

    norm_done   = work[INT_W-1] || (exp_count == '0);
    mant_last   = (mant_count == MC_W'(MANT_BITS - 1));
    out_free    = !out_valid || out_ready;

    rem_doubled    = {remainder, 1'b0};
    frac_bit       = (rem_doubled >= FRAC_SCALE);
    remainder_next = frac_bit ? FRAC_W'(rem_doubled - FRAC_SCALE) : rem_doubled[FRAC_W-1:0];
    use_int_bit    = (int_bits_left != '0);
    mant_bit       = use_int_bit ? work[INT_W-2] : frac_bit;

    unique case (ctrl.cond)
      COND_NEWLINE:   cond_hit = accept && is_newline;
      COND_NORM_DONE: cond_hit = norm_done;
      COND_MANT_DONE: cond_hit = mant_last;
      COND_OUT_FREE:  cond_hit = out_free;
    endcase
    step_next = cond_hit ? ctrl.target : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step               <= STEP_IDLE;
      out_valid          <= 1'b0;
      sign_seen_negative <= 1'b0;
      sign_taken         <= 1'b0;
      int_accumulator    <= '0;
      int_digit_count    <= '0;
      frac_accumulator   <= '0;
      frac_digit_count   <= '0;
      after_dot          <= 1'b0;
      error_seen         <= 1'b0;
    end else begin
      step <= step_next;
      if ((ctrl.op == OP_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_TAKE_CHAR: begin
          if (accept) begin
            if (is_newline) begin
              work       <= int_accumulator;
              exp_count  <= EXP_TOP;
              remainder  <= frac_accumulator;
              mant_count <= '0;
            end else if (is_sign) begin
              if (sign_taken || (int_digit_count != '0) || after_dot) begin
                error_seen <= 1'b1;
              end else begin
                sign_taken         <= 1'b1;
                sign_seen_negative <= (char_code == CH_MINUS);
              end
            end else if (is_dot) begin
              if (after_dot) begin
                error_seen <= 1'b1;
              end else begin
                after_dot <= 1'b1;
              end
            end else if (is_digit) begin
              if (!after_dot) begin
                if (int_digit_count >= ICNT_W'(INT_DIGITS)) begin
                  error_seen <= 1'b1;
                end else begin
                  if ((int_digit_count == '0) && (digit == 2'd0)) begin
                    error_seen <= 1'b1;
                  end
                  int_accumulator <= int_acc_next;
                  int_digit_count <= int_digit_count + 1'b1;
                end
              end else begin
                if (frac_digit_count >= FCNT_W'(FRAC_DIGITS)) begin
                  error_seen <= 1'b1;
                end else begin
                  frac_accumulator <= frac_accumulator + frac_addend;
                  frac_digit_count <= frac_digit_count + 1'b1;
                end
              end
            end else begin
              error_seen <= 1'b1;
            end
          end
        end
        OP_NORMALIZE: begin
          if (!norm_done) begin
            work      <= work << 1;
            exp_count <= exp_count - 1'b1;
          end else begin
            int_bits_left <= exp_count;
          end
        end
        OP_MANTISSA: begin
          mant       <= MANT_BITS'({mant, mant_bit});
          mant_count <= mant_count + 1'b1;
          if (use_int_bit) begin
            work          <= work << 1;
            int_bits_left <= int_bits_left - 1'b1;
          end else begin
            remainder <= remainder_next;
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            negative           <= sign_seen_negative;
            integer_part       <= int_accumulator;
            fraction_numerator <= frac_accumulator;
            binary_exponent    <= exp_count;
            mantissa_bits      <= mant;
            malformed          <= error_seen || !after_dot || (int_digit_count == '0);
            sign_seen_negative <= 1'b0;
            sign_taken         <= 1'b0;
            int_accumulator    <= '0;
            int_digit_count    <= '0;
            frac_accumulator   <= '0;
            frac_digit_count   <= '0;
            after_dot          <= 1'b0;
            error_seen         <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

@@ sv/ttbf_checker.sv @@
// ----------------------------------------------------------------------------
// Ternary text to binary float checker
// Port-level checks on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module ttbf_checker #(
  parameter int MANT_BITS = ttbf_pkg::MANT_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [ttbf_pkg::CHAR_W-1:0] char_code,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        negative,
  input logic [ttbf_pkg::INT_W-1:0]  integer_part,
  input logic [ttbf_pkg::FRAC_W-1:0] fraction_numerator,
  input logic [ttbf_pkg::EXP_W-1:0]  binary_exponent,
  input logic [MANT_BITS-1:0]        mantissa_bits,
  input logic                        malformed
);
  import ttbf_pkg::*;

  // A newline transfer always starts the conversion, so input stalls next.
  a_newline_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (char_code == CH_NEWLINE)) |=> !in_ready)
    else $error("input still ready after a newline transfer");

  // A new result only appears while the input side is held off.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while characters were being taken");

  // The exponent marks the leading one of the integer part.
  a_exponent_lead: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (integer_part != '0)) |-> ((integer_part >> binary_exponent) == 32'd1))
    else $error("exponent does not mark the leading one");

  a_exponent_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (integer_part == '0)) |-> (binary_exponent == '0))
    else $error("nonzero exponent for a zero integer part");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(negative)
      && $stable(integer_part) && $stable(fraction_numerator)
      && $stable(binary_exponent) && $stable(mantissa_bits) && $stable(malformed)))
    else $error("stalled result changed before its transfer");

endmodule

bind ternary_text_to_binary_float_core ttbf_checker #(.MANT_BITS(MANT_BITS)) u_ttbf_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .char_code          (char_code),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .negative           (negative),
  .integer_part       (integer_part),
  .fraction_numerator (fraction_numerator),
  .binary_exponent    (binary_exponent),
  .mantissa_bits      (mantissa_bits),
  .malformed          (malformed)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Ternary text to binary float core testbench
// Sends base-3 number text one character per transfer, with random gaps on
// both sides, and checks every result against a built-in parser model.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import ttbf_pkg::*;

  localparam int MB           = MANT_BITS_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic [CHAR_W-1:0] char_t;

  typedef struct {
    logic              negative;
    logic [INT_W-1:0]  integer_part;
    logic [FRAC_W-1:0] fraction;
    logic [EXP_W-1:0]  exponent;
    logic [MB-1:0]     mantissa;
    logic              malformed;
  } ttbf_result_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_LEADING_ZERO,
    FLAW_NO_DOT,
    FLAW_EMPTY_INT,
    FLAW_LONG_INT,
    FLAW_LONG_FRAC,
    FLAW_EXTRA_DOT,
    FLAW_LATE_SIGN,
    FLAW_BAD_CHAR
  } flaw_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  char_t             char_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              negative;
  logic [INT_W-1:0]  integer_part;
  logic [FRAC_W-1:0] fraction_numerator;
  logic [EXP_W-1:0]  binary_exponent;
  logic [MB-1:0]     mantissa_bits;
  logic              malformed;

  ttbf_result_t pending_results[$];
  int           mismatch_count = 0;
  int           chars_sent = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  bit           sender_gaps = 1'b1;
  bit           receiver_stalls = 1'b1;

  logic                p_negative;
  logic                p_sign_taken;
  logic [INT_W-1:0]    p_int_value;
  int                  p_int_count;
  logic [FRAC_W-1:0]   p_frac_value;
  logic [WEIGHT_W-1:0] p_weight;
  int                  p_frac_count;
  logic                p_after_dot;
  logic                p_error;

  ternary_text_to_binary_float_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .char_code          (char_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .negative           (negative),
    .integer_part       (integer_part),
    .fraction_numerator (fraction_numerator),
    .binary_exponent    (binary_exponent),
    .mantissa_bits      (mantissa_bits),
    .malformed          (malformed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic char_t digit(input int d);
    return CH_ZERO + char_t'(d);
  endfunction

  // Mostly short pauses, sometimes a long one.
  function automatic int random_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  task automatic parser_clear();
    p_negative   = 1'b0;
    p_sign_taken = 1'b0;
    p_int_value  = '0;
    p_int_count  = 0;
    p_frac_value = '0;
    p_weight     = 15'd19683;
    p_frac_count = 0;
    p_after_dot  = 1'b0;
    p_error      = 1'b0;
  endtask

  task automatic parse_char(input char_t c);
    ttbf_result_t r;
    logic [63:0]  mant_wide;
    logic [31:0]  remainder;
    int           lead;
    int           digit_val;
    if (c == CH_NEWLINE) begin
      lead = 0;
      for (int p = 1; p < INT_W; p++)
        if ((p_int_value >> p) != 0) lead = p;
      if (lead >= MB) begin
        mant_wide = 64'(p_int_value) >> (lead - MB);
      end else begin
        // Integer bits below the leading one, then fraction bits by doubling.
        mant_wide = 64'(p_int_value) & ((64'd1 << lead) - 64'd1);
        remainder = 32'(p_frac_value);
        for (int k = 0; k < MB - lead; k++) begin
          remainder = remainder << 1;
          mant_wide = mant_wide << 1;
          if (remainder >= 32'(FRAC_SCALE)) begin
            remainder    = remainder - 32'(FRAC_SCALE);
            mant_wide[0] = 1'b1;
          end
        end
      end
      r.negative     = p_negative;
      r.integer_part = p_int_value;
      r.fraction     = p_frac_value;
      r.exponent     = lead[EXP_W-1:0];
      r.mantissa     = mant_wide[MB-1:0];
      r.malformed    = p_error || !p_after_dot || (p_int_count == 0);
      pending_results.push_back(r);
      parser_clear();
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (p_sign_taken || p_int_count != 0 || p_after_dot) begin
        p_error = 1'b1;
      end else begin
        p_sign_taken = 1'b1;
        p_negative   = (c == CH_MINUS);
      end
    end else if (c == CH_DOT) begin
      if (p_after_dot) p_error = 1'b1;
      else p_after_dot = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_TWO) begin
      digit_val = int'(c - CH_ZERO);
      if (!p_after_dot) begin
        if (p_int_count >= INT_DIGITS_DEF) begin
          p_error = 1'b1;
        end else begin
          if (p_int_count == 0 && digit_val == 0) p_error = 1'b1;
          p_int_value = p_int_value * 32'd3 + 32'(digit_val);
          p_int_count++;
        end
      end else begin
        if (p_frac_count >= FRAC_DIGITS_DEF) begin
          p_error = 1'b1;
        end else begin
          p_frac_value = 16'(32'(p_frac_value) + 32'(digit_val) * 32'(p_weight));
          p_weight     = p_weight / 15'd3;
          p_frac_count++;
        end
      end
    end else begin
      p_error = 1'b1;
    end
  endtask

  task automatic send_char(input char_t c);
    int gap;
    gap = sender_gaps ? random_pause() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    parse_char(c);
  endtask

  task automatic send_chars(input char_t s[$]);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // One number line: mostly well formed, with random content and lengths.
  task automatic send_number();
    char_t q[$];
    char_t c;
    flaw_t flaw;
    int    int_len;
    int    frac_len;
    int    sign_sel;
    int    d;
    bit    all_twos;
    flaw = FLAW_NONE;
    if ($urandom_range(0, 99) >= 75)
      flaw = flaw_t'($urandom_range(int'(FLAW_LEADING_ZERO), int'(FLAW_BAD_CHAR)));
    case ($urandom_range(0, 9))
      0:       int_len = 1;
      1:       int_len = INT_DIGITS_DEF;
      default: int_len = $urandom_range(1, INT_DIGITS_DEF);
    endcase
    case ($urandom_range(0, 9))
      0:       frac_len = 0;
      1:       frac_len = FRAC_DIGITS_DEF;
      default: frac_len = $urandom_range(0, FRAC_DIGITS_DEF);
    endcase
    if (flaw == FLAW_EMPTY_INT) int_len = 0;
    if (flaw == FLAW_LONG_INT) int_len = $urandom_range(INT_DIGITS_DEF + 1, INT_DIGITS_DEF + 4);
    if (flaw == FLAW_LONG_FRAC)
      frac_len = $urandom_range(FRAC_DIGITS_DEF + 1, FRAC_DIGITS_DEF + 4);
    all_twos = ($urandom_range(0, 7) == 0);
    sign_sel = $urandom_range(0, 2);
    if (sign_sel == 1) q.push_back(CH_PLUS);
    else if (sign_sel == 2) q.push_back(CH_MINUS);
    for (int i = 0; i < int_len; i++) begin
      if (i == 0 && flaw == FLAW_LEADING_ZERO) d = 0;
      else if (all_twos) d = 2;
      else if (i == 0) d = $urandom_range(1, 2);
      else d = $urandom_range(0, 2);
      q.push_back(digit(d));
    end
    if (flaw != FLAW_NO_DOT) q.push_back(CH_DOT);
    for (int i = 0; i < frac_len; i++)
      q.push_back(digit(all_twos ? 2 : $urandom_range(0, 2)));
    case (flaw)
      FLAW_EXTRA_DOT: q.insert($urandom_range(0, q.size()), CH_DOT);
      FLAW_LATE_SIGN: q.insert($urandom_range(1, q.size()),
                               ($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
      FLAW_BAD_CHAR: begin
        do c = char_t'($urandom_range(0, 255));
        while (c == CH_NEWLINE || c == CH_PLUS || c == CH_MINUS || c == CH_DOT ||
               (c >= CH_ZERO && c <= CH_TWO));
        q.insert($urandom_range(0, q.size()), c);
      end
      default: ;
    endcase
    q.push_back(CH_NEWLINE);
    send_chars(q);
  endtask

  task automatic test_directed_forms();
    char_t s[$];
    s = {CH_MINUS, digit(2), CH_DOT, digit(1), digit(2), CH_NEWLINE};
    send_chars(s);
  endtask

  task automatic test_directed_errors();
    char_t s[$];
    s = {digit(0), CH_DOT, CH_NEWLINE};
    send_chars(s);
    s = {digit(2), CH_NEWLINE};
    send_chars(s);
    s = {CH_DOT, digit(2), digit(1), CH_NEWLINE};
    send_chars(s);
    s = {CH_MINUS, CH_PLUS, digit(1), CH_DOT, CH_PLUS, CH_DOT, 8'h00, 8'hFF, CH_NEWLINE};
    send_chars(s);
  endtask

  task automatic test_random_numbers(input int count);
    int start;
    start = chars_sent;
    while (chars_sent - start < count) send_number();
  endtask

  task automatic test_drained_numbers(input int lines);
    for (int i = 0; i < lines; i++) begin
      send_number();
      wait_results_drained();
    end
  endtask

  task automatic test_back_to_back(input int count);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    test_random_numbers(count);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_random_noise(input int count);
    char_t c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        4:       c = CH_NEWLINE;
        5:       c = CH_PLUS;
        6:       c = CH_MINUS;
        7:       c = CH_DOT;
        8, 9:    c = digit($urandom_range(0, 2));
        default: c = char_t'($urandom_range(0, 255));
      endcase
      send_char(c);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    ttbf_result_t exp_r;
    int           pause;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: neg=%0b int=%0d frac=%0d exp=%0d mant=%h bad=%0b",
                   negative, integer_part, fraction_numerator, binary_exponent,
                   mantissa_bits, malformed);
      end else begin
        exp_r = pending_results.pop_front();
        if (negative !== exp_r.negative || integer_part !== exp_r.integer_part ||
            fraction_numerator !== exp_r.fraction || binary_exponent !== exp_r.exponent ||
            mantissa_bits !== exp_r.mantissa || malformed !== exp_r.malformed) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch expected: neg=%0b int=%0d frac=%0d exp=%0d mant=%h bad=%0b",
                     exp_r.negative, exp_r.integer_part, exp_r.fraction, exp_r.exponent,
                     exp_r.mantissa, exp_r.malformed);
            $display("         actual:   neg=%0b int=%0d frac=%0d exp=%0d mant=%h bad=%0b",
                     negative, integer_part, fraction_numerator, binary_exponent,
                     mantissa_bits, malformed);
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      pause = receiver_stalls ? random_pause() : 0;
      if (pause == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left = pause - 1;
      end
    end
  end

  initial begin
    parser_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_forms();
    test_directed_errors();
    test_random_numbers(650);
    test_drained_numbers(6);
    test_back_to_back(350);
    test_random_noise(250);
    test_random_numbers(300);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
